// ===== hw/rtl/dcc_pkg.sv =====
package dcc_pkg;

    // Byte position counter, saturating
    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Datagram layout
    localparam int unsigned HDR_SIZE    = 32;
    localparam int unsigned CRC_SIZE    = 4;
    localparam int unsigned FRAME_FIXED = 28;
    localparam int unsigned MIN_LEN     = HDR_SIZE + CRC_SIZE;

    // Captured header bytes (flags through payload length)
    localparam int unsigned HDR_LO = 5;
    localparam int unsigned HDR_HI = 27;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TOO_SHORT   = 3'd1,
        STATUS_BAD_MAGIC   = 3'd2,
        STATUS_BAD_VERSION = 3'd3,
        STATUS_LEN_MISMATCH = 3'd4,
        STATUS_CRC_MISMATCH = 3'd5
    } dcc_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } dcc_in_t;

    typedef struct packed {
        dcc_status_t status;
        logic [7:0]  flags;
        logic [7:0]  capture_mode;
        logic [31:0] device_id;
        logic [31:0] boot_id;
        logic [31:0] packet_seq;
        logic [31:0] batch_seq;
        logic [15:0] frame_count;
        logic [15:0] payload_len;
        logic [15:0] frames_walked;
        logic        frame_overrun;
    } dcc_out_t;

    // One accepted beat as seen by the sub-blocks
    typedef struct packed {
        logic               advance;
        logic               finish;
        logic [COUNT_W-1:0] pos;
        logic [7:0]         data;
    } dcc_step_t;

    // Header view after the current beat
    typedef struct packed {
        logic [7:0]  flags;
        logic [7:0]  capture_mode;
        logic [31:0] device_id;
        logic [31:0] boot_id;
        logic [31:0] packet_seq;
        logic [31:0] batch_seq;
        logic [15:0] frame_count;
        logic [15:0] payload_len;
        logic        magic_ok;
        logic        version_ok;
    } dcc_hdr_t;

endpackage

// ===== hw/rtl/dcc_stream_if.sv =====
interface dcc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dcc_header_capture.sv =====
module dcc_header_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  dcc_pkg::dcc_step_t  step,
    input  logic [31:0]         magic_word,
    input  logic [7:0]          expected_version,
    output dcc_pkg::dcc_hdr_t   hdr
);

    logic [7:0] hdr_reg  [dcc_pkg::HDR_LO:dcc_pkg::HDR_HI];
    logic [7:0] hdr_next [dcc_pkg::HDR_LO:dcc_pkg::HDR_HI];
    logic       magic_ok_reg;
    logic       magic_ok_next;
    logic       version_ok_reg;
    logic       version_ok_next;
    logic [7:0] magic_byte;

    // Write the header byte that sits at the current position
    always_comb
    begin
        for (int k = dcc_pkg::HDR_LO; k <= dcc_pkg::HDR_HI; k++)
        begin
            hdr_next[k] = (step.advance && step.pos == dcc_pkg::COUNT_W'(k))
                          ? step.data : hdr_reg[k];
        end
    end

    // Check magic and version bytes as they pass
    always_comb
    begin
        magic_byte      = magic_word[8*step.pos[1:0] +: 8];
        magic_ok_next   = magic_ok_reg;
        version_ok_next = version_ok_reg;
        if (step.advance && step.pos < dcc_pkg::COUNT_W'(4) && step.data != magic_byte)
        begin
            magic_ok_next = 1'b0;
        end
        if (step.advance && step.pos == dcc_pkg::COUNT_W'(4) && step.data != expected_version)
        begin
            version_ok_next = 1'b0;
        end
    end

    // Hold captured bytes; drop them at the end of a datagram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = dcc_pkg::HDR_LO; k <= dcc_pkg::HDR_HI; k++)
            begin
                hdr_reg[k] <= 8'h00;
            end
            magic_ok_reg   <= 1'b1;
            version_ok_reg <= 1'b1;
        end
        else if (step.finish)
        begin
            for (int k = dcc_pkg::HDR_LO; k <= dcc_pkg::HDR_HI; k++)
            begin
                hdr_reg[k] <= 8'h00;
            end
            magic_ok_reg   <= 1'b1;
            version_ok_reg <= 1'b1;
        end
        else
        begin
            for (int k = dcc_pkg::HDR_LO; k <= dcc_pkg::HDR_HI; k++)
            begin
                hdr_reg[k] <= hdr_next[k];
            end
            magic_ok_reg   <= magic_ok_next;
            version_ok_reg <= version_ok_next;
        end
    end

    // Assemble little-endian fields
    assign hdr.flags        = hdr_next[5];
    assign hdr.capture_mode = hdr_next[6];
    assign hdr.device_id    = {hdr_next[11], hdr_next[10], hdr_next[9], hdr_next[8]};
    assign hdr.boot_id      = {hdr_next[15], hdr_next[14], hdr_next[13], hdr_next[12]};
    assign hdr.packet_seq   = {hdr_next[19], hdr_next[18], hdr_next[17], hdr_next[16]};
    assign hdr.batch_seq    = {hdr_next[23], hdr_next[22], hdr_next[21], hdr_next[20]};
    assign hdr.frame_count  = {hdr_next[25], hdr_next[24]};
    assign hdr.payload_len  = {hdr_next[27], hdr_next[26]};
    assign hdr.magic_ok     = magic_ok_next;
    assign hdr.version_ok   = version_ok_next;

endmodule

// ===== hw/rtl/dcc_crc_tail.sv =====
module dcc_crc_tail (
    input  logic               clk,
    input  logic               rst_n,
    input  dcc_pkg::dcc_step_t step,
    output logic [7:0]         delayed_byte,
    output logic               delayed_valid,
    output logic               crc_match
);

    logic [7:0]  tail_reg  [0:3];
    logic [7:0]  tail_next [0:3];
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] stored_crc;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (dcc_pkg::CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // Bytes leave the delay line four beats after they arrive
    assign delayed_byte  = tail_reg[0];
    assign delayed_valid = step.advance && step.pos >= dcc_pkg::COUNT_W'(dcc_pkg::CRC_SIZE);

    // Shift the tail and fold the leaving byte into the CRC
    always_comb
    begin
        tail_next[0] = tail_reg[1];
        tail_next[1] = tail_reg[2];
        tail_next[2] = tail_reg[3];
        tail_next[3] = step.data;
        crc_next     = delayed_valid ? crc_byte(crc_reg, tail_reg[0]) : crc_reg;
    end

    assign stored_crc = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};
    assign crc_match  = (~crc_next) == stored_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                tail_reg[k] <= 8'h00;
            end
            crc_reg <= dcc_pkg::CRC_INIT;
        end
        else if (step.finish)
        begin
            for (int k = 0; k < 4; k++)
            begin
                tail_reg[k] <= 8'h00;
            end
            crc_reg <= dcc_pkg::CRC_INIT;
        end
        else if (step.advance)
        begin
            for (int k = 0; k < 4; k++)
            begin
                tail_reg[k] <= tail_next[k];
            end
            crc_reg <= crc_next;
        end
    end

endmodule

// ===== hw/rtl/dcc_frame_walker.sv =====
module dcc_frame_walker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dcc_pkg::dcc_step_t          step,
    input  logic [7:0]                  body_byte,
    input  logic                        body_valid,
    output logic [dcc_pkg::COUNT_W-1:0] frame_start,
    output logic [15:0]                 frames_done
);

    localparam int unsigned WIDE_W = dcc_pkg::COUNT_W + 1;

    logic [dcc_pkg::COUNT_W-1:0] start_reg;
    logic [dcc_pkg::COUNT_W-1:0] start_next;
    logic [15:0]                 csi_reg;
    logic [15:0]                 csi_next;
    logic [15:0]                 csi_word;
    logic [15:0]                 done_reg;
    logic [15:0]                 done_next;
    logic [WIDE_W-1:0]           q_wide;
    logic [WIDE_W-1:0]           start_wide;
    logic [WIDE_W-1:0]           end_wide;
    logic                        active;
    logic                        at_len_lo;
    logic                        at_len_hi;
    logic                        past_hdr;
    logic                        frame_end;

    // Body offset of the byte leaving the delay line
    assign q_wide     = WIDE_W'(step.pos - dcc_pkg::COUNT_W'(dcc_pkg::CRC_SIZE));
    assign start_wide = WIDE_W'(start_reg);
    assign active     = body_valid && q_wide >= start_wide;
    assign at_len_lo  = q_wide == start_wide + WIDE_W'(dcc_pkg::FRAME_FIXED - 2);
    assign at_len_hi  = q_wide == start_wide + WIDE_W'(dcc_pkg::FRAME_FIXED - 1);
    assign past_hdr   = q_wide >= start_wide + WIDE_W'(dcc_pkg::FRAME_FIXED - 1);
    assign csi_word   = at_len_hi ? (csi_reg | {body_byte, 8'h00}) : csi_reg;
    assign end_wide   = start_wide + WIDE_W'(dcc_pkg::FRAME_FIXED) + WIDE_W'(csi_word);
    assign frame_end  = active && !at_len_lo && past_hdr
                        && (q_wide + WIDE_W'(1)) == end_wide;

    // Advance to the next frame when the current one closes
    always_comb
    begin
        start_next = start_reg;
        done_next  = done_reg;
        csi_next   = csi_reg;
        if (frame_end)
        begin
            start_next = end_wide > WIDE_W'(dcc_pkg::COUNT_MAX)
                         ? dcc_pkg::COUNT_MAX : end_wide[dcc_pkg::COUNT_W-1:0];
            if (done_reg != 16'hFFFF)
            begin
                done_next = done_reg + 16'd1;
            end
            csi_next = 16'h0000;
        end
        else if (active && at_len_lo)
        begin
            csi_next = {8'h00, body_byte};
        end
        else if (active && at_len_hi)
        begin
            csi_next = csi_word;
        end
    end

    assign frame_start = start_next;
    assign frames_done = done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= dcc_pkg::COUNT_W'(dcc_pkg::HDR_SIZE);
            csi_reg   <= 16'h0000;
            done_reg  <= 16'h0000;
        end
        else if (step.finish)
        begin
            start_reg <= dcc_pkg::COUNT_W'(dcc_pkg::HDR_SIZE);
            csi_reg   <= 16'h0000;
            done_reg  <= 16'h0000;
        end
        else
        begin
            start_reg <= start_next;
            csi_reg   <= csi_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== hw/rtl/datagram_checker_crc32.sv =====
// Datagram checker: takes one received datagram a byte per beat, last byte
// flagged, and returns one status beat per datagram in the cycle after the last
// byte is taken. A byte is accepted every cycle; the input stalls only when a
// last byte arrives while the previous status is still waiting downstream.
// The cycle path is the byte-wide CRC-32 update feeding the CRC compare.
// The status reports the first failing check in the order too short, bad
// magic, bad version, length mismatch, CRC mismatch, together with the captured
// header fields and the frame walk result. The user must write magic_word
// and expected_version only while no datagram is in progress; not enforced.
module datagram_checker_crc32 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    dcc_stream_if.sink                      in_stream,
    dcc_stream_if.source                    out_stream
);

    logic [31:0]                 magic_reg;
    logic [7:0]                  version_reg;
    logic [dcc_pkg::COUNT_W-1:0] count_reg;
    logic [dcc_pkg::COUNT_W-1:0] count_next;
    logic                        out_valid_reg;
    dcc_pkg::dcc_out_t           out_reg;
    dcc_pkg::dcc_out_t           out_next;
    dcc_pkg::dcc_step_t          step;
    dcc_pkg::dcc_hdr_t           hdr;
    dcc_pkg::dcc_in_t            in_beat;
    logic [7:0]                  delayed_byte;
    logic                        delayed_valid;
    logic                        crc_match;
    logic [dcc_pkg::COUNT_W-1:0] frame_start;
    logic [15:0]                 frames_done;
    logic                        accept;
    logic                        long_enough;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 32'h0;
            version_reg <= 8'h0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcc_pkg::CFG_MAGIC_WORD:       magic_reg   <= cfg_data[31:0];
                dcc_pkg::CFG_EXPECTED_VERSION: version_reg <= cfg_data[7:0];
                default:                       magic_reg   <= magic_reg;
            endcase
        end
    end

    // Take bytes freely; hold a last byte until the status slot is free
    assign in_beat         = in_stream.payload;
    assign in_stream.ready = !in_beat.last_byte || !out_valid_reg || out_stream.ready;
    assign accept          = in_stream.valid && in_stream.ready;

    assign step.advance = accept;
    assign step.finish  = accept && in_beat.last_byte;
    assign step.pos     = count_reg;
    assign step.data    = in_beat.data_byte;

    // Saturating byte position
    assign count_next = (count_reg == dcc_pkg::COUNT_MAX) ? count_reg
                        : count_reg + dcc_pkg::COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step.finish)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    dcc_header_capture u_header (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .magic_word       (magic_reg),
        .expected_version (version_reg),
        .hdr              (hdr)
    );

    dcc_crc_tail u_crc (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .delayed_byte  (delayed_byte),
        .delayed_valid (delayed_valid),
        .crc_match     (crc_match)
    );

    dcc_frame_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .body_byte   (delayed_byte),
        .body_valid  (delayed_valid),
        .frame_start (frame_start),
        .frames_done (frames_done)
    );

    // Resolve status for the datagram ending on this beat
    assign long_enough = count_next >= dcc_pkg::COUNT_W'(dcc_pkg::MIN_LEN);

    always_comb
    begin
        if (!long_enough)
        begin
            out_next.status = dcc_pkg::STATUS_TOO_SHORT;
        end
        else if (!hdr.magic_ok)
        begin
            out_next.status = dcc_pkg::STATUS_BAD_MAGIC;
        end
        else if (!hdr.version_ok)
        begin
            out_next.status = dcc_pkg::STATUS_BAD_VERSION;
        end
        else if ((dcc_pkg::COUNT_W + 1)'(hdr.payload_len)
                 + (dcc_pkg::COUNT_W + 1)'(dcc_pkg::MIN_LEN)
                 != (dcc_pkg::COUNT_W + 1)'(count_next))
        begin
            out_next.status = dcc_pkg::STATUS_LEN_MISMATCH;
        end
        else if (!crc_match)
        begin
            out_next.status = dcc_pkg::STATUS_CRC_MISMATCH;
        end
        else
        begin
            out_next.status = dcc_pkg::STATUS_OK;
        end
        out_next.flags         = hdr.flags;
        out_next.capture_mode  = hdr.capture_mode;
        out_next.device_id     = hdr.device_id;
        out_next.boot_id       = hdr.boot_id;
        out_next.packet_seq    = hdr.packet_seq;
        out_next.batch_seq     = hdr.batch_seq;
        out_next.frame_count   = hdr.frame_count;
        out_next.payload_len   = hdr.payload_len;
        out_next.frames_walked = frames_done;
        out_next.frame_overrun = long_enough
            && (count_next - dcc_pkg::COUNT_W'(dcc_pkg::CRC_SIZE)) > frame_start;
    end

    // Status output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_stream.valid   = out_valid_reg;
    assign out_stream.payload = out_reg;

endmodule
